/* rtl/obbfc_pkg.sv */
// Package for the oriented box frustum classifier.
// Holds field widths, stream word layout and result codes.
// No dependencies; used by obb_frustum_classify.
package obbfc_pkg;

    localparam int MAX_PLANES   = 4;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 48;

    localparam int COORD_W      = 32;
    localparam int VEC_W        = 48;
    localparam int COMP_W       = 16;
    localparam int EXT_W        = 31;

    localparam int AXIS_PROD_W  = 2 * COMP_W;
    localparam int DOT_SUM_W    = AXIS_PROD_W + 1;
    localparam int DOT_ABS_W    = AXIS_PROD_W;
    localparam int CEN_PROD_W   = COMP_W + COORD_W;
    localparam int OFF_SHIFT    = 14;
    localparam int OFF_SCALED_W = COORD_W + OFF_SHIFT;
    localparam int DIST_W       = CEN_PROD_W + 1;
    localparam int TERM_W       = DOT_ABS_W + EXT_W;
    localparam int RADIUS_W     = TERM_W + 2;
    localparam int CMP_W        = RADIUS_W + 2;

    localparam int IN_DATA_W    = 336;
    localparam int CEN_LSB      = 0;
    localparam int AXIS_LSB     = 3 * COORD_W;
    localparam int EXT_LSB      = AXIS_LSB + 3 * VEC_W;
    localparam int OUT_DATA_W   = 8;

    localparam logic [1:0] CLASS_OUTSIDE  = 2'd0;
    localparam logic [1:0] CLASS_TOUCHING = 2'd1;
    localparam logic [1:0] CLASS_INSIDE   = 2'd2;

endpackage

/* rtl/obb_frustum_classify.sv */
// Top level of the oriented box frustum classifier, a five stage pipeline.
// Depends on obbfc_pkg for widths, word layout and result codes.
//
// Usage: each input word on the s_axis channel is one oriented box; the
// block tests it against PLANE_COUNT side planes held in configuration
// registers and returns one result word on the m_axis channel per box.
// Planes are to be written through the cfg channel (index 2p is the normal of
// plane p, index 2p+1 its offset) only while no box is in flight; the block
// itself does not enforce this, and cfg_ready is always high.
// A new box is accepted in every cycle unless a full output register is stalled,
// so throughput is one box per cycle; the depth is set by the products, the
// absolute dot products, the radius multipliers (one 32 by 31 bit multiplier per
// axis and plane), the radius sum and the final compare and output register.
// Reset clears all plane registers to zero and empties the pipeline.
// When the receiver stalls, the whole pipeline holds and s_axis_tready
// drops; nothing is lost or repeated, and bubbles do not block input while
// the output register is empty.
module obb_frustum_classify #(
    parameter int PLANE_COUNT = obbfc_pkg::MAX_PLANES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [obbfc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [obbfc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: center_x, center_y, center_z, axis_first,
    // axis_second, axis_third, extent_first, extent_second, extent_third.
    input  logic [obbfc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0: box_absent.
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: classification (2 bits), box_visible.
    output logic [obbfc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int NSTAGE = 4;

    logic [obbfc_pkg::VEC_W-1:0]   normal_reg [PLANE_COUNT];
    logic [obbfc_pkg::COORD_W-1:0] offset_reg [PLANE_COUNT];

    logic                          advance;
    logic [NSTAGE-1:0]             vld_reg;
    logic [NSTAGE-1:0]             vld_next;
    logic [NSTAGE-1:0]             absent_reg;
    logic [obbfc_pkg::EXT_W-1:0]   ext_s1_reg [3];
    logic [obbfc_pkg::EXT_W-1:0]   ext_s2_reg [3];

    logic [PLANE_COUNT-1:0]        lt_neg;
    logic [PLANE_COUNT-1:0]        le_neg;
    logic [PLANE_COUNT-1:0]        le_pos;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [1:0]                    class_reg;
    logic [1:0]                    class_next;
    logic                          visible_reg;
    logic                          visible_next;

    assign cfg_ready     = 1'b1;
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(obbfc_pkg::OUT_DATA_W - 3){1'b0}}, visible_reg, class_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                normal_reg[p] <= '0;
                offset_reg[p] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                if (32'(cfg_index[obbfc_pkg::CFG_INDEX_W-1:1]) == p)
                begin
                    if (cfg_index[0])
                        offset_reg[p] <= cfg_data[obbfc_pkg::COORD_W-1:0];
                    else
                        normal_reg[p] <= cfg_data;
                end
            end
        end
    end

    assign vld_next = {vld_reg[NSTAGE-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            absent_reg <= {absent_reg[NSTAGE-2:0], s_axis_tuser};
            for (int k = 0; k < 3; k++)
            begin
                ext_s1_reg[k] <= s_axis_tdata[obbfc_pkg::EXT_LSB + k*obbfc_pkg::EXT_W
                                              +: obbfc_pkg::EXT_W];
                ext_s2_reg[k] <= ext_s1_reg[k];
            end
        end
    end

    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_plane
        logic signed [obbfc_pkg::AXIS_PROD_W-1:0]  aprod_next [3][3];
        logic signed [obbfc_pkg::AXIS_PROD_W-1:0]  aprod_reg  [3][3];
        logic signed [obbfc_pkg::CEN_PROD_W-1:0]   cprod_next [3];
        logic signed [obbfc_pkg::CEN_PROD_W-1:0]   cprod_reg  [3];
        logic signed [obbfc_pkg::OFF_SCALED_W-1:0] off_reg;
        logic signed [obbfc_pkg::DOT_SUM_W-1:0]    dsum       [3];
        logic [obbfc_pkg::DOT_ABS_W-1:0]           dot_next   [3];
        logic [obbfc_pkg::DOT_ABS_W-1:0]           dot_reg    [3];
        logic signed [obbfc_pkg::DIST_W-1:0]       dist_next;
        logic signed [obbfc_pkg::DIST_W-1:0]       dist_s2_reg;
        logic signed [obbfc_pkg::DIST_W-1:0]       dist_s3_reg;
        logic signed [obbfc_pkg::DIST_W-1:0]       dist_s4_reg;
        logic [obbfc_pkg::TERM_W-1:0]              term_next  [3];
        logic [obbfc_pkg::TERM_W-1:0]              term_reg   [3];
        logic [obbfc_pkg::RADIUS_W-1:0]            radius_next;
        logic [obbfc_pkg::RADIUS_W-1:0]            radius_reg;
        logic signed [obbfc_pkg::CMP_W-1:0]        dist_cmp;
        logic signed [obbfc_pkg::CMP_W-1:0]        radius_cmp;
        logic signed [obbfc_pkg::CMP_W-1:0]        sum_cmp;
        logic signed [obbfc_pkg::CMP_W-1:0]        diff_cmp;

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    aprod_next[k][c] =
                        $signed(normal_reg[p][c*obbfc_pkg::COMP_W +: obbfc_pkg::COMP_W])
                        * $signed(s_axis_tdata[obbfc_pkg::AXIS_LSB + k*obbfc_pkg::VEC_W
                                               + c*obbfc_pkg::COMP_W +: obbfc_pkg::COMP_W]);
                end
                cprod_next[k] =
                    $signed(normal_reg[p][k*obbfc_pkg::COMP_W +: obbfc_pkg::COMP_W])
                    * $signed(s_axis_tdata[obbfc_pkg::CEN_LSB + k*obbfc_pkg::COORD_W
                                           +: obbfc_pkg::COORD_W]);
            end
        end

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                dsum[k]     = aprod_reg[k][0] + aprod_reg[k][1] + aprod_reg[k][2];
                dot_next[k] = dsum[k][obbfc_pkg::DOT_SUM_W-1]
                            ? obbfc_pkg::DOT_ABS_W'(-dsum[k])
                            : dsum[k][obbfc_pkg::DOT_ABS_W-1:0];
                term_next[k] = dot_reg[k] * ext_s2_reg[k];
            end
            dist_next   = cprod_reg[0] + cprod_reg[1] + cprod_reg[2] + off_reg;
            radius_next = term_reg[0] + term_reg[1] + term_reg[2];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                aprod_reg   <= aprod_next;
                cprod_reg   <= cprod_next;
                off_reg     <= {$signed(offset_reg[p]), {obbfc_pkg::OFF_SHIFT{1'b0}}};
                dot_reg     <= dot_next;
                dist_s2_reg <= dist_next;
                term_reg    <= term_next;
                dist_s3_reg <= dist_s2_reg;
                radius_reg  <= radius_next;
                dist_s4_reg <= dist_s3_reg;
            end
        end

        always_comb
        begin
            dist_cmp   = {{(obbfc_pkg::CMP_W - obbfc_pkg::DIST_W - obbfc_pkg::OFF_SHIFT)
                           {dist_s4_reg[obbfc_pkg::DIST_W-1]}},
                          dist_s4_reg, {obbfc_pkg::OFF_SHIFT{1'b0}}};
            radius_cmp = {{(obbfc_pkg::CMP_W - obbfc_pkg::RADIUS_W){1'b0}}, radius_reg};
            sum_cmp    = dist_cmp + radius_cmp;
            diff_cmp   = radius_cmp - dist_cmp;
            lt_neg[p]  = sum_cmp[obbfc_pkg::CMP_W-1];
            le_neg[p]  = sum_cmp[obbfc_pkg::CMP_W-1] || (sum_cmp == '0);
            le_pos[p]  = !diff_cmp[obbfc_pkg::CMP_W-1];
        end
    end

    always_comb
    begin
        out_valid_next = advance ? vld_reg[NSTAGE-1] : out_valid_reg;
        if (absent_reg[NSTAGE-1])
        begin
            class_next   = obbfc_pkg::CLASS_INSIDE;
            visible_next = 1'b1;
        end
        else
        begin
            if (|lt_neg)
                class_next = obbfc_pkg::CLASS_OUTSIDE;
            else if (|le_pos)
                class_next = obbfc_pkg::CLASS_TOUCHING;
            else
                class_next = obbfc_pkg::CLASS_INSIDE;
            visible_next = !(|le_neg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            class_reg   <= class_next;
            visible_reg <= visible_next;
        end
    end

    // An absent box always leaves as inside and visible.
    a_absent_inside: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTAGE-1] && absent_reg[NSTAGE-1] && advance
        |=> m_axis_tvalid && class_reg == obbfc_pkg::CLASS_INSIDE && visible_reg)
        else $error("absent box not reported as inside and visible");

    // A box outside some plane can never be visible.
    a_outside_hidden: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && class_reg == obbfc_pkg::CLASS_OUTSIDE |-> !visible_reg)
        else $error("outside box flagged visible");

    // A box fully inside all planes is always visible.
    a_inside_visible: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && class_reg == obbfc_pkg::CLASS_INSIDE |-> visible_reg)
        else $error("inside box flagged not visible");

    // Input back-pressure only comes from a full output register.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output can move");

endmodule

/* dv/tb_obb_frustum_classify.sv */
`timescale 1ns / 1ps
// Testbench for obb_frustum_classify: streams oriented boxes under several plane sets,
// predicts each verdict in exact wide arithmetic and checks every result word.
// Depends on obbfc_pkg and the obb_frustum_classify RTL only.
module tb_obb_frustum_classify;

    localparam int NUM_PLANES   = obbfc_pkg::MAX_PLANES;
    localparam int REG_STRIDE   = 2;
    localparam int REG_NORMAL   = 0;
    localparam int REG_OFFSET   = 1;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BOXES  = 100;
    localparam int HOLD_BOXES   = 40;
    localparam int SCENE_SPAN   = 1 << 20;
    localparam int SCENE_EXTENT = 1 << 18;
    localparam int OFFSET_SPAN  = 1 << 21;
    localparam logic [31:0] BOUND = 32'h0005_0000;
    localparam logic [47:0] UNIT_X = 48'h0000_0000_4000;

    typedef struct packed {
        logic             absent;
        logic [2:0][30:0] ext;
        logic [2:0][47:0] axis;
        logic [2:0][31:0] cen;
    } box_t;

    typedef struct packed {
        logic       vis;
        logic [1:0] cls;
    } verdict_t;

    typedef enum int { SHAPE_SCENE, SHAPE_RAW, SHAPE_ABSENT } box_shape_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [obbfc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [obbfc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [obbfc_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                              s_axis_tuser = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [obbfc_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

    logic [47:0] plane_normal [NUM_PLANES] = '{default: '0};
    logic [31:0] plane_offset [NUM_PLANES] = '{default: '0};
    verdict_t    pending_verdicts [$];
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    logic        rx_hold = 1'b0;
    int          mismatches = 0;
    int          boxes_sent = 0;
    int          verdicts_seen = 0;
    int          cycles = 0;
    int          class_count [4] = '{default: 0};

    obb_frustum_classify #(
        .PLANE_COUNT(NUM_PLANES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Radius and center distance are both compared in the Q28 scale, at 96 bits.
    function automatic verdict_t classify_box(box_t b);
        verdict_t               v;
        logic signed [15:0]     nc [3];
        logic signed [15:0]     ac;
        logic signed [31:0]     cen_s;
        logic signed [31:0]     ext_s;
        logic signed [31:0]     off_s;
        logic signed [95:0]     dot;
        logic signed [95:0]     radius;
        logic signed [95:0]     center_dist;
        logic                   outside;
        logic                   touching;
        int                     p;
        int                     k;
        int                     j;
        v.cls = obbfc_pkg::CLASS_INSIDE;
        v.vis = 1'b1;
        if (b.absent)
            return v;
        outside = 1'b0;
        touching = 1'b0;
        for (p = 0; p < NUM_PLANES; p++)
        begin
            for (k = 0; k < 3; k++)
                nc[k] = plane_normal[p][16*k +: 16];
            radius = '0;
            for (k = 0; k < 3; k++)
            begin
                dot = '0;
                for (j = 0; j < 3; j++)
                begin
                    ac = b.axis[k][16*j +: 16];
                    dot = dot + nc[j] * ac;
                end
                if (dot < 0)
                    dot = -dot;
                ext_s = {1'b0, b.ext[k]};
                radius = radius + dot * ext_s;
            end
            off_s = plane_offset[p];
            center_dist = off_s * 16384;
            for (k = 0; k < 3; k++)
            begin
                cen_s = b.cen[k];
                center_dist = center_dist + nc[k] * cen_s;
            end
            center_dist = center_dist * 16384;
            if (center_dist < -radius)
                outside = 1'b1;
            if (center_dist <= radius)
                touching = 1'b1;
            if (center_dist <= -radius)
                v.vis = 1'b0;
        end
        v.cls = outside ? obbfc_pkg::CLASS_OUTSIDE
              : (touching ? obbfc_pkg::CLASS_TOUCHING : obbfc_pkg::CLASS_INSIDE);
        return v;
    endfunction

    function automatic box_t make_box(box_shape_t shape);
        box_t b;
        int   k;
        for (k = 0; k < 3; k++)
        begin
            b.cen[k]  = $urandom();
            b.axis[k] = 48'({$urandom(), $urandom()});
            b.ext[k]  = 31'($urandom());
            if (shape == SHAPE_SCENE)
            begin
                b.cen[k] = 32'($urandom_range(0, 2 * SCENE_SPAN) - SCENE_SPAN);
                b.ext[k] = 31'($urandom_range(0, SCENE_EXTENT));
            end
        end
        b.absent = (shape == SHAPE_ABSENT);
        return b;
    endfunction

    function automatic box_shape_t random_shape();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return SHAPE_ABSENT;
        if (roll < 30)
            return SHAPE_RAW;
        return SHAPE_SCENE;
    endfunction

    function automatic box_t box_on_x(logic [31:0] cx, logic [30:0] e);
        box_t b;
        b = '0;
        b.cen[0] = cx;
        b.axis[0] = UNIT_X;
        b.ext[0] = e;
        return b;
    endfunction

    function automatic box_t extreme_box(logic hi);
        box_t b;
        int   k;
        b.absent = 1'b0;
        for (k = 0; k < 3; k++)
        begin
            b.cen[k]  = hi ? 32'h7FFF_FFFF : 32'h8000_0000;
            b.axis[k] = hi ? 48'h7FFF_7FFF_7FFF : 48'h8000_8000_8000;
            b.ext[k]  = '1;
        end
        return b;
    endfunction

    task automatic send_box(box_t b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, b.ext, b.axis, b.cen};
        s_axis_tuser  <= b.absent;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_verdicts.push_back(classify_box(b));
        boxes_sent++;
    endtask

    task automatic write_reg(int idx, logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= obbfc_pkg::CFG_INDEX_W'(idx);
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx % REG_STRIDE == REG_OFFSET)
            plane_offset[idx / REG_STRIDE] = value[31:0];
        else
            plane_normal[idx / REG_STRIDE] = value;
    endtask

    task automatic set_planes(logic [3:0][47:0] normals, logic [3:0][47:0] offsets);
        int p;
        for (p = 0; p < NUM_PLANES; p++)
        begin
            write_reg(p * REG_STRIDE + REG_NORMAL, normals[p]);
            write_reg(p * REG_STRIDE + REG_OFFSET, offsets[p]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic randomize_planes();
        logic [3:0][47:0] normals;
        logic [3:0][47:0] offsets;
        int               p;
        for (p = 0; p < NUM_PLANES; p++)
        begin
            normals[p] = 48'({$urandom(), $urandom()});
            offsets[p] = {16'($urandom()),
                          32'($urandom_range(0, 2 * OFFSET_SPAN) - OFFSET_SPAN)};
        end
        set_planes(normals, offsets);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_planes();
        send_box(make_box(SHAPE_ABSENT));
        send_box(make_box(SHAPE_RAW));
        send_box(make_box(SHAPE_SCENE));
        send_box(extreme_box(1'b1));
        wait_drained();
    endtask

    // Plane 0 faces +x through the origin, the others are always satisfied,
    // so a box on the x axis lands exactly on each comparison edge.
    task automatic test_boundaries();
        logic [3:0][47:0] normals;
        logic [3:0][47:0] offsets;
        normals = '0;
        normals[0] = UNIT_X;
        offsets = '0;
        offsets[1] = 48'h0001_0000;
        offsets[2] = 48'h0001_0000;
        offsets[3] = 48'h0001_0000;
        set_planes(normals, offsets);
        send_box(box_on_x(BOUND, BOUND[30:0]));
        send_box(box_on_x(-BOUND, BOUND[30:0]));
        send_box(box_on_x(-BOUND - 32'd1, BOUND[30:0]));
        send_box(box_on_x(BOUND + 32'd1, BOUND[30:0]));
        send_box(box_on_x(32'd0, 31'd0));
        send_box(box_on_x(32'd1, 31'd0));
        send_box(make_box(SHAPE_ABSENT));
        send_box(extreme_box(1'b1));
        send_box(extreme_box(1'b0));
        wait_drained();
    endtask

    task automatic test_extreme_planes();
        logic [3:0][47:0] normals;
        logic [3:0][47:0] offsets;
        normals = {4{48'h8000_8000_8000}};
        offsets = {4{48'hFFFF_8000_0000}};
        set_planes(normals, offsets);
        send_box(extreme_box(1'b1));
        send_box(extreme_box(1'b0));
        send_box(make_box(SHAPE_SCENE));
        wait_drained();
        normals = {4{48'h7FFF_7FFF_7FFF}};
        offsets = {4{48'h0000_7FFF_FFFF}};
        set_planes(normals, offsets);
        send_box(extreme_box(1'b1));
        send_box(extreme_box(1'b0));
        send_box(make_box(SHAPE_SCENE));
        wait_drained();
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct, int count);
        randomize_planes();
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) send_box(make_box(random_shape()));
        wait_drained();
    endtask

    task automatic test_backpressure();
        randomize_planes();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            begin
                repeat (HOLD_BOXES) send_box(make_box(random_shape()));
            end
        join
        wait_drained();
    endtask

    always @(posedge clk)
    begin : result_check
        verdict_t got;
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[2:0];
            verdicts_seen++;
            class_count[got.cls]++;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                $error("Unexpected result word: classification %0d, box_visible %0d",
                       got.cls, got.vis);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.cls !== want.cls)
                begin
                    mismatches++;
                    $error("classification mismatch: expected %0d, actual %0d",
                           want.cls, got.cls);
                end
                if (got.vis !== want.vis)
                begin
                    mismatches++;
                    $error("box_visible mismatch: expected %0d, actual %0d",
                           want.vis, got.vis);
                end
            end
        end
        m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_planes();
        test_boundaries();
        test_extreme_planes();
        test_random_traffic(0, 0, PHASE_BOXES);
        test_random_traffic(82, 0, PHASE_BOXES);
        test_random_traffic(0, 82, PHASE_BOXES);
        test_random_traffic(26, 26, PHASE_BOXES);
        test_backpressure();
        $display("Sent %0d boxes over reset, boundary, extreme and random plane sets,",
                 boxes_sent);
        $display("with a long output stall; %0d words: %0d outside, %0d touching, %0d inside.",
                 verdicts_seen, class_count[obbfc_pkg::CLASS_OUTSIDE],
                 class_count[obbfc_pkg::CLASS_TOUCHING],
                 class_count[obbfc_pkg::CLASS_INSIDE]);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
